// ===== hw/rtl/aav_pkg.sv =====
// Types, constants and helper functions shared by the velocity-angle CORDIC.
package aav_pkg;

  localparam int VW = 60;  // vector datapath width
  localparam int AW = 34;  // angle accumulator width, 2^-24 degree units
  localparam int TAB_LEN = 32;

  localparam logic signed [AW-1:0] DEG90 = 34'sd1509949440;
  localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
  localparam logic signed [AW-1:0] PITCH_MAX = 34'sd11796480;
  localparam logic signed [AW-1:0] YAW_MAX = 34'sd5898240;

  localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [24:0] pitch_angle;
    logic signed [23:0] yaw_angle;
    logic        [23:0] total_angle;
  } out_item_t;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic signed [AW-1:0] ang;
  } lane_t;

  typedef struct packed {
    logic signed [31:0]   x;
    logic signed [31:0]   y;
    logic signed [AW-1:0] pacc;
    logic                 pitch_zero;
    logic                 yaw_zero;
    logic                 total_zero;
  } side_t;

  typedef struct packed {
    lane_t l0;
    lane_t l1;
    side_t sd;
  } pair_t;

  // 32-bit component scaled by 2^24 into the datapath width
  function automatic logic signed [VW-1:0] scale_in(logic signed [31:0] v);
    scale_in = {{(VW-56){v[31]}}, v, 24'b0};
  endfunction

  // fold the left half plane into the right by a +-90 degree turn
  function automatic lane_t prerot(logic signed [VW-1:0] a, logic signed [VW-1:0] b);
    lane_t r;
    r.a = a;
    r.b = b;
    r.ang = '0;
    if (a[VW-1]) begin
      if (!b[VW-1]) begin
        r.a = b;
        r.b = -a;
        r.ang = DEG90;
      end else begin
        r.a = -b;
        r.b = a;
        r.ang = -DEG90;
      end
    end
    return r;
  endfunction

  // round half up to 2^-16 degree and clamp
  function automatic logic signed [25:0] to_out(logic signed [AW-1:0] acc,
                                                 logic signed [AW-1:0] lo,
                                                 logic signed [AW-1:0] hi);
    logic signed [AW-1:0] v;
    v = (acc + AW'(128)) >>> 8;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[25:0];
  endfunction

endpackage

// ===== hw/rtl/aav_cell.sv =====
// One CORDIC vectoring micro-rotation on two lanes, registered.
module aav_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  aav_pkg::pair_t d_i,
  output aav_pkg::pair_t q_o
);

  aav_pkg::pair_t q_r;
  aav_pkg::pair_t q_nxt;

  function automatic aav_pkg::lane_t vrot(aav_pkg::lane_t l);
    aav_pkg::lane_t r;
    logic signed [aav_pkg::VW-1:0] da;
    logic signed [aav_pkg::VW-1:0] db;
    da = l.b >>> IDX;
    db = l.a >>> IDX;
    if (!l.b[aav_pkg::VW-1]) begin
      r.a = l.a + da;
      r.b = l.b - db;
      r.ang = l.ang + aav_pkg::ATAN_TAB[IDX];
    end else begin
      r.a = l.a - da;
      r.b = l.b + db;
      r.ang = l.ang - aav_pkg::ATAN_TAB[IDX];
    end
    return r;
  endfunction

  always_comb begin
    q_nxt.l0 = vrot(d_i.l0);
    q_nxt.l1 = vrot(d_i.l1);
    q_nxt.sd = d_i.sd;
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

// ===== hw/rtl/aero_angles_from_velocity.sv =====
// Top level: pipelined CORDIC computing pitch, sideslip and total angle from velocity.
// Takes one velocity item per clock while in_stall is low and returns its three angles.
// After an entry register that scales and pre-rotates, two rows of CORDIC_STAGES
// cells run back to back: the first vectors (x,z) and (y,z) side by side, a
// gain-multiply stage and a pre-rotation stage follow, the second row vectors
// (|xz|,y) and (x,|yz|), and an output register rounds and clamps. When out_stall
// holds a waiting result, the whole pipeline freezes and in_stall rises in the same
// cycle; bubbles inside do not block intake.
module aero_angles_from_velocity #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aav_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output aav_pkg::out_item_t out_item
);

  localparam int N = CORDIC_STAGES;
  localparam int L = 2 * N + 4;

  typedef struct packed {
    logic signed [aav_pkg::VW-1:0] m_xz;
    logic signed [aav_pkg::VW-1:0] m_yz;
    logic signed [aav_pkg::VW-1:0] gy;
    logic signed [aav_pkg::VW-1:0] gx;
    aav_pkg::side_t                sd;
  } gain_t;

  logic [L-1:0] vld_r;
  logic [L-1:0] vld_nxt;
  logic         en;

  aav_pkg::pair_t     p0_r, p0_nxt;
  aav_pkg::pair_t     c1_q [N];
  gain_t              g_r, g_nxt;
  aav_pkg::pair_t     p2_r, p2_nxt;
  aav_pkg::pair_t     c2_q [N];
  aav_pkg::out_item_t out_r, out_nxt;

  assign en = !(vld_r[L-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt = {vld_r[L-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // entry: scale and pre-rotate
  always_comb begin
    p0_nxt.l0 = aav_pkg::prerot(aav_pkg::scale_in(in_item.vel_x),
                                aav_pkg::scale_in(in_item.vel_z));
    p0_nxt.l1 = aav_pkg::prerot(aav_pkg::scale_in(in_item.vel_y),
                                aav_pkg::scale_in(in_item.vel_z));
    p0_nxt.sd.x = in_item.vel_x;
    p0_nxt.sd.y = in_item.vel_y;
    p0_nxt.sd.pacc = '0;
    p0_nxt.sd.pitch_zero = (in_item.vel_x == '0) && (in_item.vel_z == '0);
    p0_nxt.sd.yaw_zero = (in_item.vel_x == '0) && (in_item.vel_y == '0)
                         && (in_item.vel_z == '0);
    p0_nxt.sd.total_zero = (in_item.vel_x == '0);
  end

  always_ff @(posedge clk) begin
    if (en) p0_r <= p0_nxt;
  end

  for (genvar i = 0; i < N; i++) begin : g_row1
    aav_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .d_i ((i == 0) ? p0_r : c1_q[(i == 0) ? 0 : i-1]),
      .q_o (c1_q[i])
    );
  end

  // carry the CORDIC gain onto the raw operand of each second pass
  always_comb begin
    logic signed [63:0] py;
    logic signed [63:0] px;
    py = c1_q[N-1].sd.y * $signed({1'b0, aav_pkg::GAIN_Q30});
    px = c1_q[N-1].sd.x * $signed({1'b0, aav_pkg::GAIN_Q30});
    g_nxt.gy = aav_pkg::VW'(py >>> 6);
    g_nxt.gx = aav_pkg::VW'(px >>> 6);
    g_nxt.m_xz = c1_q[N-1].l0.a;
    g_nxt.m_yz = c1_q[N-1].l1.a;
    g_nxt.sd = c1_q[N-1].sd;
    g_nxt.sd.pacc = c1_q[N-1].l0.ang;
  end

  always_ff @(posedge clk) begin
    if (en) g_r <= g_nxt;
  end

  always_comb begin
    p2_nxt.l0 = aav_pkg::prerot(g_r.m_xz, g_r.gy);
    p2_nxt.l1 = aav_pkg::prerot(g_r.gx, g_r.m_yz);
    p2_nxt.sd = g_r.sd;
    p2_nxt.sd.x = '0;
    p2_nxt.sd.y = '0;
  end

  always_ff @(posedge clk) begin
    if (en) p2_r <= p2_nxt;
  end

  for (genvar i = 0; i < N; i++) begin : g_row2
    aav_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .d_i ((i == 0) ? p2_r : c2_q[(i == 0) ? 0 : i-1]),
      .q_o (c2_q[i])
    );
  end

  always_comb begin
    logic signed [25:0] rp;
    logic signed [25:0] ry;
    logic signed [25:0] rt;
    rp = aav_pkg::to_out(c2_q[N-1].sd.pacc, -aav_pkg::PITCH_MAX, aav_pkg::PITCH_MAX);
    ry = aav_pkg::to_out(c2_q[N-1].l0.ang, -aav_pkg::YAW_MAX, aav_pkg::YAW_MAX);
    rt = aav_pkg::to_out(c2_q[N-1].l1.ang, '0, aav_pkg::PITCH_MAX);
    out_nxt.pitch_angle = c2_q[N-1].sd.pitch_zero ? '0 : rp[24:0];
    out_nxt.yaw_angle = c2_q[N-1].sd.yaw_zero ? '0 : ry[23:0];
    out_nxt.total_angle = c2_q[N-1].sd.total_zero ? '0 : rt[23:0];
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_valid = vld_r[L-1];
  assign out_item = out_r;

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("intake open while result is held");

  a_total_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.total_angle <= 24'd11796480)
    else $error("total angle out of range");

  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.pitch_angle <= 25'sd11796480)
                  && (out_item.pitch_angle >= -25'sd11796480))
    else $error("pitch angle out of range");

endmodule

// ===== test/tb.sv =====
// Testbench for aero_angles_from_velocity: random and directed items against a CORDIC predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 24;
  localparam int LATENCY = 2 * STAGES + 4;
  localparam longint SCALE = 64'sd16777216;
  localparam longint GAIN = 64'sd1768195363;
  localparam longint RIGHT_ANGLE = 64'sd1509949440;
  localparam longint PITCH_LIM = 64'sd11796480;
  localparam longint YAW_LIM = 64'sd5898240;

  // Angle predictor: vectoring CORDIC in 64-bit arithmetic.
  class angle_board;
    aav_pkg::out_item_t angles_q[$];
    int errors;

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint vectorize(longint a, longint b, output longint mag);
      longint ang, t, da, db;
      int n;
      ang = 0;
      n = (STAGES > 32) ? 32 : STAGES;
      if (a < 0) begin
        t = a;
        if (b >= 0) begin
          a = b; b = -t; ang = RIGHT_ANGLE;
        end else begin
          a = -b; b = t; ang = -RIGHT_ANGLE;
        end
      end
      for (int i = 0; i < n; i++) begin
        da = floor_shr(b, i);
        db = floor_shr(a, i);
        if (b >= 0) begin
          a += da; b -= db; ang += longint'(aav_pkg::ATAN_TAB[i]);
        end else begin
          a -= da; b += db; ang -= longint'(aav_pkg::ATAN_TAB[i]);
        end
      end
      mag = a;
      return ang;
    endfunction

    function longint round_clamp(longint acc, longint lo, longint hi);
      longint v;
      v = floor_shr(acc + 128, 8);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void note_velocity(aav_pkg::in_item_t it);
      longint x, y, z, m_xz, m_yz, spare, ang;
      aav_pkg::out_item_t r;
      x = it.vel_x; y = it.vel_y; z = it.vel_z;
      r = '0;
      ang = vectorize(x * SCALE, z * SCALE, m_xz);
      if (!(x == 0 && z == 0)) r.pitch_angle = 25'(round_clamp(ang, -PITCH_LIM, PITCH_LIM));
      if (!(x == 0 && y == 0 && z == 0)) begin
        ang = vectorize(m_xz, floor_shr(y * GAIN, 6), spare);
        r.yaw_angle = 24'(round_clamp(ang, -YAW_LIM, YAW_LIM));
      end
      if (x != 0) begin
        ang = vectorize(y * SCALE, z * SCALE, m_yz);
        ang = vectorize(floor_shr(x * GAIN, 6), m_yz, spare);
        r.total_angle = 24'(round_clamp(ang, 0, PITCH_LIM));
      end
      angles_q.push_back(r);
    endfunction

    function void check_angles(aav_pkg::out_item_t got);
      aav_pkg::out_item_t exp;
      if (angles_q.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      exp = angles_q.pop_front();
      if (got.pitch_angle !== exp.pitch_angle) begin
        $error("pitch_angle: expected %0d, got %0d", exp.pitch_angle, got.pitch_angle);
        errors++;
      end
      if (got.yaw_angle !== exp.yaw_angle) begin
        $error("yaw_angle: expected %0d, got %0d", exp.yaw_angle, got.yaw_angle);
        errors++;
      end
      if (got.total_angle !== exp.total_angle) begin
        $error("total_angle: expected %0d, got %0d", exp.total_angle, got.total_angle);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  aav_pkg::in_item_t in_item;
  aav_pkg::out_item_t out_item;
  angle_board board;
  bit calm;

  aero_angles_from_velocity #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("aero_angles_from_velocity regression: fail");
    $finish;
  end

  // Input and result acceptance, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_velocity(in_item);
    if (rst_n && out_valid && !out_stall) board.check_angles(out_item);
  end

  // Receiver stalls in random bursts.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  function logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed(32'($urandom_range(0, 8))) - 4;
      4: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_velocity(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
    in_item <= '{vel_x: x, vel_y: y, vel_z: z};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.angles_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] edges [5];
    edges = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1};
    board = new();
    calm = 0;
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // all zero, x zero, x and z zero, extremes, half-plane crossings
    send_velocity(0, 0, 0);
    send_velocity(0, 5, 0);
    send_velocity(0, 100, -100);
    send_velocity(-65536, 0, 0);
    send_velocity(-65536, 0, -1);
    send_velocity(-65536, 1, 1);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        send_velocity(edges[i], edges[(i + j) % 5], edges[(i + 2 * j) % 5]);
    drain();
    for (int n = 0; n < 800; n++) begin
      if (n == 650) calm = 1;
      send_velocity(rand_comp(), rand_comp(), rand_comp());
    end
    drain();
    if (board.errors == 0 && board.angles_q.size() == 0)
      $display("aero_angles_from_velocity regression: pass");
    else
      $display("aero_angles_from_velocity regression: fail");
    $finish;
  end
endmodule
